/* src/sbt_pkg.sv */
// Shared types and constants of the source byte tokenizer.
`timescale 1ns / 1ps
`default_nettype none

package sbt_pkg;

  // Output field widths
  localparam int unsigned KIND_W  = 6;
  localparam int unsigned FIELD_W = 20;

  // Default width of the saturating byte position counter
  localparam int unsigned POSITION_BITS_DEF = 20;

  // Results one source byte can cause at most
  localparam int unsigned MAX_RESULTS = 4;
  localparam int unsigned RES_CNT_W   = 3;

  // Identifier prefix register: five bytes, newest byte lowest
  localparam int unsigned PREFIX_W = 40;

  localparam logic [PREFIX_W-1:0] KW_LET   = 40'h00_006c_6574;
  localparam logic [PREFIX_W-1:0] KW_TRUE  = 40'h00_7472_7565;
  localparam logic [PREFIX_W-1:0] KW_FALSE = 40'h66_616c_7365;
  localparam logic [PREFIX_W-1:0] KW_NULL  = 40'h00_6e75_6c6c;

  // Characters with a role of their own
  localparam logic [7:0] CH_UNDERSCORE = 8'h5f;
  localparam logic [7:0] CH_NEWLINE    = 8'h0a;

  // Token kinds
  typedef enum logic [KIND_W-1:0] {
    TK_END      = 6'd0,
    TK_IDENT    = 6'd1,
    TK_NUMBER   = 6'd2,
    TK_STRING   = 6'd3,
    TK_LET      = 6'd4,
    TK_TRUE     = 6'd5,
    TK_FALSE    = 6'd6,
    TK_NULL     = 6'd7,
    TK_ASSIGN   = 6'd8,
    TK_EQEQ     = 6'd9,
    TK_BANG     = 6'd10,
    TK_NEQ      = 6'd11,
    TK_LT       = 6'd12,
    TK_LE       = 6'd13,
    TK_GT       = 6'd14,
    TK_GE       = 6'd15,
    TK_ANDAND   = 6'd16,
    TK_OROR     = 6'd17,
    TK_PIPEGT   = 6'd18,
    TK_PLUS     = 6'd19,
    TK_MINUS    = 6'd20,
    TK_STAR     = 6'd21,
    TK_SLASH    = 6'd22,
    TK_PERCENT  = 6'd23,
    TK_LPAREN   = 6'd24,
    TK_RPAREN   = 6'd25,
    TK_LBRACE   = 6'd26,
    TK_RBRACE   = 6'd27,
    TK_LBRACKET = 6'd28,
    TK_RBRACKET = 6'd29,
    TK_COMMA    = 6'd30,
    TK_DOT      = 6'd31,
    TK_COLON    = 6'd32,
    TK_SEMI     = 6'd33,
    TK_UNKNOWN  = 6'd34
  } tok_kind_e;

  // One result record
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [FIELD_W-1:0] start;
    logic [FIELD_W-1:0] length;
    logic               last;
  } tok_rec_t;

  // Burst of results handed from the scanner to the output buffer
  typedef struct packed {
    logic                            load;
    logic [RES_CNT_W-1:0]            count;
    tok_rec_t [MAX_RESULTS-1:0]      rec;
  } tok_burst_t;

endpackage

`default_nettype wire

/* src/sbt_if.sv */
// Valid/ready channel interfaces for source bytes and tokens.
`timescale 1ns / 1ps
`default_nettype none

interface sbt_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;
  logic       is_final;

  modport source (output valid, output source_byte, output is_final, input ready);
  modport sink (input valid, input source_byte, input is_final, output ready);
endinterface

interface sbt_token_if;
  logic                        valid;
  logic                        ready;
  logic [sbt_pkg::KIND_W-1:0]  token_kind;
  logic [sbt_pkg::FIELD_W-1:0] token_start;
  logic [sbt_pkg::FIELD_W-1:0] token_length;
  logic                        run_last;

  modport source (output valid, output token_kind, output token_start,
                  output token_length, output run_last, input ready);
  modport sink (input valid, input token_kind, input token_start,
                input token_length, input run_last, output ready);
endinterface

`default_nettype wire

/* src/sbt_scan.sv */
// Input register, scanner state and single-pass token logic.
`timescale 1ns / 1ps
`default_nettype none

module sbt_scan #(
  parameter int unsigned POSITION_BITS = sbt_pkg::POSITION_BITS_DEF
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  sbt_byte_if.sink          byte_i,
  input  wire               room_i,
  output sbt_pkg::tok_burst_t burst_o
);

  localparam int unsigned NCAND = 6;

  typedef logic [POSITION_BITS-1:0] pos_t;

  typedef enum logic [3:0] {
    M_IDLE    = 4'd0,
    M_EQ      = 4'd1,
    M_BANG    = 4'd2,
    M_LT      = 4'd3,
    M_GT      = 4'd4,
    M_AMP     = 4'd5,
    M_PIPE    = 4'd6,
    M_SLASH   = 4'd7,
    M_COMMENT = 4'd8,
    M_STRING  = 4'd9,
    M_IDENT   = 4'd10,
    M_INT     = 4'd11,
    M_INTDOT  = 4'd12,
    M_FRAC    = 4'd13
  } mode_e;

  localparam pos_t POS_MAX = {POSITION_BITS{1'b1}};
  localparam pos_t POS_ONE = pos_t'(1);

  // Input register and scanner state
  logic                              vld_q;
  logic [7:0]                        byte_q;
  logic                              fin_q;
  mode_e                             mode_q, mode_d;
  pos_t                              pos_q, pos_d;
  pos_t                              start_q, start_d;
  logic [sbt_pkg::PREFIX_W-1:0]      kp_q, kp_d;

  logic fire;

  // Candidate results in emission order
  logic [NCAND-1:0]                  cand_v;
  sbt_pkg::tok_rec_t [NCAND-1:0]     cand;

  logic                              consumed;
  logic                              punct_hit;
  sbt_pkg::tok_kind_e                punct_k;
  pos_t                              inc_p, pm1, incl, excl, end_p, end_m1, flen;
  logic [7:0]                        c;
  logic [sbt_pkg::RES_CNT_W-1:0]     n;

  // Distance from a to b, zero when b is not past a
  function automatic pos_t span(input pos_t a, input pos_t b);
    return (b > a) ? (b - a) : '0;
  endfunction

  // Mask a position value to the output field width
  function automatic logic [sbt_pkg::FIELD_W-1:0] to_field(input pos_t v);
    logic [POSITION_BITS+sbt_pkg::FIELD_W-1:0] w;
    w = {{sbt_pkg::FIELD_W{1'b0}}, v};
    return w[sbt_pkg::FIELD_W-1:0];
  endfunction

  function automatic sbt_pkg::tok_rec_t mk(input sbt_pkg::tok_kind_e k, input pos_t s,
                                           input pos_t l);
    sbt_pkg::tok_rec_t r;
    r.kind   = k;
    r.start  = to_field(s);
    r.length = to_field(l);
    r.last   = 1'b0;
    return r;
  endfunction

  function automatic sbt_pkg::tok_kind_e ident_kind(input logic [sbt_pkg::PREFIX_W-1:0] kp);
    sbt_pkg::tok_kind_e k;
    if (kp == sbt_pkg::KW_LET) k = sbt_pkg::TK_LET;
    else if (kp == sbt_pkg::KW_TRUE) k = sbt_pkg::TK_TRUE;
    else if (kp == sbt_pkg::KW_FALSE) k = sbt_pkg::TK_FALSE;
    else if (kp == sbt_pkg::KW_NULL) k = sbt_pkg::TK_NULL;
    else k = sbt_pkg::TK_IDENT;
    return k;
  endfunction

  function automatic logic is_digit(input logic [7:0] ch);
    return (ch >= "0") && (ch <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] ch);
    return ((ch >= "a") && (ch <= "z")) || ((ch >= "A") && (ch <= "Z"));
  endfunction

  function automatic logic is_space(input logic [7:0] ch);
    return (ch == " ") || ((ch >= 8'd9) && (ch <= 8'd13));
  endfunction

  // Accept a new byte when the register is empty or drains this cycle
  assign fire         = vld_q && room_i;
  assign byte_i.ready = !vld_q || fire;

  assign c      = byte_q;
  assign inc_p  = (pos_q == POS_MAX) ? pos_q : pos_q + POS_ONE;
  assign pm1    = span(POS_ONE, pos_q);
  assign incl   = span(start_q, inc_p);
  assign excl   = span(start_q, pos_q);
  assign end_p  = inc_p;
  assign end_m1 = span(POS_ONE, end_p);

  // Single-character punctuation lookup
  always_comb begin
    punct_hit = 1'b1;
    case (c)
      "+":     punct_k = sbt_pkg::TK_PLUS;
      "-":     punct_k = sbt_pkg::TK_MINUS;
      "*":     punct_k = sbt_pkg::TK_STAR;
      "%":     punct_k = sbt_pkg::TK_PERCENT;
      "(":     punct_k = sbt_pkg::TK_LPAREN;
      ")":     punct_k = sbt_pkg::TK_RPAREN;
      "{":     punct_k = sbt_pkg::TK_LBRACE;
      "}":     punct_k = sbt_pkg::TK_RBRACE;
      "[":     punct_k = sbt_pkg::TK_LBRACKET;
      "]":     punct_k = sbt_pkg::TK_RBRACKET;
      ",":     punct_k = sbt_pkg::TK_COMMA;
      ".":     punct_k = sbt_pkg::TK_DOT;
      ":":     punct_k = sbt_pkg::TK_COLON;
      ";":     punct_k = sbt_pkg::TK_SEMI;
      default: begin
        punct_k   = sbt_pkg::TK_UNKNOWN;
        punct_hit = 1'b0;
      end
    endcase
  end

  // Next state and candidate results for the registered byte
  always_comb begin
    mode_d   = mode_q;
    start_d  = start_q;
    kp_d     = kp_q;
    pos_d    = pos_q;
    consumed = 1'b0;
    cand_v   = '0;
    cand     = '0;
    flen     = '0;

    // Offer the byte to the pending token
    unique case (mode_q)
      M_EQ, M_BANG, M_LT, M_GT: begin
        if (c == "=") begin
          consumed = 1'b1;
          mode_d   = M_IDLE;
          cand_v[0] = 1'b1;
          cand[0]   = mk((mode_q == M_EQ)   ? sbt_pkg::TK_EQEQ :
                         (mode_q == M_BANG) ? sbt_pkg::TK_NEQ :
                         (mode_q == M_LT)   ? sbt_pkg::TK_LE : sbt_pkg::TK_GE,
                         start_q, incl);
        end else begin
          cand_v[0] = 1'b1;
          cand[0]   = mk((mode_q == M_EQ)   ? sbt_pkg::TK_ASSIGN :
                         (mode_q == M_BANG) ? sbt_pkg::TK_BANG :
                         (mode_q == M_LT)   ? sbt_pkg::TK_LT : sbt_pkg::TK_GT,
                         start_q, excl);
        end
      end
      M_AMP: begin
        cand_v[0] = 1'b1;
        if (c == "&") begin
          consumed = 1'b1;
          mode_d   = M_IDLE;
          cand[0]  = mk(sbt_pkg::TK_ANDAND, start_q, incl);
        end else begin
          cand[0]  = mk(sbt_pkg::TK_UNKNOWN, start_q, excl);
        end
      end
      M_PIPE: begin
        cand_v[0] = 1'b1;
        if (c == "|") begin
          consumed = 1'b1;
          mode_d   = M_IDLE;
          cand[0]  = mk(sbt_pkg::TK_OROR, start_q, incl);
        end else if (c == ">") begin
          consumed = 1'b1;
          mode_d   = M_IDLE;
          cand[0]  = mk(sbt_pkg::TK_PIPEGT, start_q, incl);
        end else begin
          cand[0]  = mk(sbt_pkg::TK_UNKNOWN, start_q, excl);
        end
      end
      M_SLASH: begin
        if (c == "/") begin
          consumed = 1'b1;
          mode_d   = M_COMMENT;
        end else begin
          cand_v[0] = 1'b1;
          cand[0]   = mk(sbt_pkg::TK_SLASH, start_q, excl);
        end
      end
      M_COMMENT: begin
        consumed = 1'b1;
        if (c == sbt_pkg::CH_NEWLINE) mode_d = M_IDLE;
      end
      M_STRING: begin
        consumed = 1'b1;
        if (c == "\"") begin
          mode_d    = M_IDLE;
          cand_v[0] = 1'b1;
          cand[0]   = mk(sbt_pkg::TK_STRING, start_q, incl);
        end
      end
      M_IDENT: begin
        if (is_alpha(c) || is_digit(c) || (c == sbt_pkg::CH_UNDERSCORE)) begin
          consumed = 1'b1;
          if (kp_q[sbt_pkg::PREFIX_W-1 -: 8] != 8'd0) begin
            kp_d = '1;
          end else begin
            kp_d = {kp_q[sbt_pkg::PREFIX_W-9:0], c};
          end
        end else begin
          cand_v[0] = 1'b1;
          cand[0]   = mk(ident_kind(kp_q), start_q, excl);
        end
      end
      M_INT: begin
        if (is_digit(c)) begin
          consumed = 1'b1;
        end else if (c == ".") begin
          consumed = 1'b1;
          mode_d   = M_INTDOT;
        end else begin
          cand_v[0] = 1'b1;
          cand[0]   = mk(sbt_pkg::TK_NUMBER, start_q, excl);
        end
      end
      M_INTDOT: begin
        if (is_digit(c)) begin
          consumed = 1'b1;
          mode_d   = M_FRAC;
        end else begin
          // Number up to the dot, then the dot on its own
          cand_v[1:0] = 2'b11;
          cand[0]     = mk(sbt_pkg::TK_NUMBER, start_q, span(start_q, pm1));
          cand[1]     = mk(sbt_pkg::TK_DOT, pm1, POS_ONE);
        end
      end
      M_FRAC: begin
        if (is_digit(c)) begin
          consumed = 1'b1;
        end else begin
          cand_v[0] = 1'b1;
          cand[0]   = mk(sbt_pkg::TK_NUMBER, start_q, excl);
        end
      end
      default: begin
        consumed = 1'b0;
      end
    endcase

    // Scan the byte afresh when no pending token took it
    if (!consumed) begin
      mode_d = M_IDLE;
      if (!is_space(c)) begin
        case (c)
          "=":  begin mode_d = M_EQ;     start_d = pos_q; end
          "!":  begin mode_d = M_BANG;   start_d = pos_q; end
          "<":  begin mode_d = M_LT;     start_d = pos_q; end
          ">":  begin mode_d = M_GT;     start_d = pos_q; end
          "&":  begin mode_d = M_AMP;    start_d = pos_q; end
          "|":  begin mode_d = M_PIPE;   start_d = pos_q; end
          "/":  begin mode_d = M_SLASH;  start_d = pos_q; end
          "\"": begin mode_d = M_STRING; start_d = pos_q; end
          default: begin
            if (punct_hit) begin
              cand_v[2] = 1'b1;
              cand[2]   = mk(punct_k, pos_q, POS_ONE);
            end else if (is_alpha(c) || (c == sbt_pkg::CH_UNDERSCORE)) begin
              mode_d  = M_IDENT;
              start_d = pos_q;
              kp_d    = {{(sbt_pkg::PREFIX_W-8){1'b0}}, c};
            end else if (is_digit(c)) begin
              mode_d  = M_INT;
              start_d = pos_q;
            end else begin
              cand_v[2] = 1'b1;
              cand[2]   = mk(sbt_pkg::TK_UNKNOWN, pos_q, POS_ONE);
            end
          end
        endcase
      end
    end

    // Flush the pending token and append End at the last byte
    if (fin_q) begin
      flen = span(start_d, end_p);
      unique case (mode_d)
        M_EQ:   begin cand_v[3] = 1'b1; cand[3] = mk(sbt_pkg::TK_ASSIGN, start_d, flen); end
        M_BANG: begin cand_v[3] = 1'b1; cand[3] = mk(sbt_pkg::TK_BANG, start_d, flen); end
        M_LT:   begin cand_v[3] = 1'b1; cand[3] = mk(sbt_pkg::TK_LT, start_d, flen); end
        M_GT:   begin cand_v[3] = 1'b1; cand[3] = mk(sbt_pkg::TK_GT, start_d, flen); end
        M_AMP, M_PIPE: begin
          cand_v[3] = 1'b1;
          cand[3]   = mk(sbt_pkg::TK_UNKNOWN, start_d, flen);
        end
        M_SLASH: begin cand_v[3] = 1'b1; cand[3] = mk(sbt_pkg::TK_SLASH, start_d, flen); end
        M_STRING: begin
          cand_v[3] = 1'b1;
          cand[3]   = mk(sbt_pkg::TK_STRING, start_d, flen);
        end
        M_IDENT: begin cand_v[3] = 1'b1; cand[3] = mk(ident_kind(kp_d), start_d, flen); end
        M_INT, M_FRAC: begin
          cand_v[3] = 1'b1;
          cand[3]   = mk(sbt_pkg::TK_NUMBER, start_d, flen);
        end
        M_INTDOT: begin
          cand_v[4:3] = 2'b11;
          cand[3]     = mk(sbt_pkg::TK_NUMBER, start_d, span(start_d, end_m1));
          cand[4]     = mk(sbt_pkg::TK_DOT, end_m1, POS_ONE);
        end
        default: begin
          cand_v[3] = 1'b0;
        end
      endcase
      cand_v[5] = 1'b1;
      cand[5]   = mk(sbt_pkg::TK_END, end_p, '0);
      mode_d    = M_IDLE;
      pos_d     = '0;
      start_d   = '0;
      kp_d      = '0;
    end else begin
      pos_d = inc_p;
    end
  end

  // Pack the candidates into consecutive result slots
  always_comb begin
    n             = '0;
    burst_o.rec   = '0;
    for (int i = 0; i < NCAND; i++) begin
      if (cand_v[i] && (n < sbt_pkg::RES_CNT_W'(sbt_pkg::MAX_RESULTS))) begin
        burst_o.rec[n[1:0]] = cand[i];
        n = n + sbt_pkg::RES_CNT_W'(1);
      end
    end
    if (n != '0) burst_o.rec[n[1:0] - 2'd1].last = 1'b1;
    burst_o.count = n;
    burst_o.load  = fire;
  end

  // Hold the byte register and scanner state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= 1'b0;
      byte_q  <= '0;
      fin_q   <= 1'b0;
      mode_q  <= M_IDLE;
      pos_q   <= '0;
      start_q <= '0;
      kp_q    <= '0;
    end else begin
      if (byte_i.valid && byte_i.ready) begin
        vld_q  <= 1'b1;
        byte_q <= byte_i.source_byte;
        fin_q  <= byte_i.is_final;
      end else if (fire) begin
        vld_q  <= 1'b0;
      end
      if (fire) begin
        mode_q  <= mode_d;
        pos_q   <= pos_d;
        start_q <= start_d;
        kp_q    <= kp_d;
      end
    end
  end

endmodule

`default_nettype wire

/* src/sbt_obuf.sv */
// Result buffer: loads a burst of up to four tokens and drains one per cycle while token ready is high.
`timescale 1ns / 1ps
`default_nettype none

module sbt_obuf (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  sbt_pkg::tok_burst_t  burst_i,
  output logic                 room_o,
  sbt_token_if.source          token_o
);

  sbt_pkg::tok_rec_t [sbt_pkg::MAX_RESULTS-1:0] slot_q;
  logic [sbt_pkg::RES_CNT_W-1:0]                cnt_q;
  logic                                         pop;

  assign pop = token_o.valid && token_o.ready;

  // Room for a new burst when the buffer is empty or empties this cycle
  assign room_o = (cnt_q == '0) || ((cnt_q == sbt_pkg::RES_CNT_W'(1)) && token_o.ready);

  // Present the head slot
  assign token_o.valid        = (cnt_q != '0);
  assign token_o.token_kind   = slot_q[0].kind;
  assign token_o.token_start  = slot_q[0].start;
  assign token_o.token_length = slot_q[0].length;
  assign token_o.run_last     = slot_q[0].last;

  // Load a burst, or advance the queue on each transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      slot_q <= '0;
    end else if (burst_i.load) begin
      cnt_q  <= burst_i.count;
      slot_q <= burst_i.rec;
    end else if (pop) begin
      cnt_q <= cnt_q - sbt_pkg::RES_CNT_W'(1);
      for (int i = 0; i < sbt_pkg::MAX_RESULTS - 1; i++) begin
        slot_q[i] <= slot_q[i+1];
      end
    end
  end

endmodule

`default_nettype wire

/* src/source_byte_tokenizer.sv */
// Top level of the source byte tokenizer.
//
// Usage: source text enters on byte_i one byte per transaction, with
// is_final set on the last byte of a source. Tokens leave on token_o as
// kind, start offset and length; run_last marks the last token a byte caused.
// A byte is registered on acceptance and scanned in the next cycle by one
// pass of logic; its tokens (up to four) load the output buffer at the edge
// at which the buffer has room, and the first token is then valid on token_o.
// Throughput: one byte per cycle while each byte causes at most one token and
// the receiver keeps ready high. A byte causing more tokens holds the next
// byte in the register while the single-token output port drains the buffer.
// When the receiver stalls, the buffer holds its tokens, the byte register
// fills and byte_i.ready falls; nothing is dropped.
// After the final byte the scanner returns to idle and the offset to zero.
// Reset clears the scanner state, the position counter and both registers;
// byte_i.ready is high as soon as reset is released.
`timescale 1ns / 1ps
`default_nettype none

module source_byte_tokenizer #(
  parameter int unsigned POSITION_BITS = sbt_pkg::POSITION_BITS_DEF
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  sbt_byte_if.sink     byte_i,
  sbt_token_if.source  token_o
);

  sbt_pkg::tok_burst_t burst;
  logic                room;

  sbt_scan #(
    .POSITION_BITS(POSITION_BITS)
  ) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .byte_i  (byte_i),
    .room_i  (room),
    .burst_o (burst)
  );

  sbt_obuf u_obuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .burst_i (burst),
    .room_o  (room),
    .token_o (token_o)
  );

endmodule

`default_nettype wire

/* tb/tb_source_byte_tokenizer.sv */
// Self-checking testbench for the source byte tokenizer with a built-in lexer predictor.
`timescale 1ns / 1ps

module tb_source_byte_tokenizer;

  localparam int unsigned POS_BITS    = sbt_pkg::POSITION_BITS_DEF;
  localparam int unsigned POS_MAX     = (1 << POS_BITS) - 1;
  localparam int unsigned CYCLE_LIMIT = 100_000;
  localparam int unsigned QUEUE_DEPTH = 64;
  localparam int unsigned DRAIN_WAIT  = 20;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned PHASE_BYTES = 55;

  // Lexer states of the predictor
  typedef enum logic [3:0] {
    SC_IDLE, SC_EQ, SC_BANG, SC_LT, SC_GT, SC_AMP, SC_PIPE, SC_SLASH,
    SC_COMMENT, SC_STRING, SC_IDENT, SC_INT, SC_INTDOT, SC_FRAC
  } scan_e;

  typedef struct packed {
    logic [7:0] value;
    logic       last_byte;
  } src_byte_t;

  logic clk_i;
  logic rst_ni;

  sbt_byte_if  byte_if ();
  sbt_token_if token_if ();

  source_byte_tokenizer #(
    .POSITION_BITS(POS_BITS)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (byte_if),
    .token_o(token_if)
  );

  // Stimulus and checking state
  src_byte_t            byte_queue[$];
  logic [7:0]           src_text[$];
  sbt_pkg::tok_rec_t    token_expect_q[$];
  sbt_pkg::tok_rec_t    step_toks[$];
  int unsigned bytes_sent     = 0;
  int unsigned fail_count     = 0;
  int unsigned cycle_count    = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  // Predictor state
  scan_e         lex_mode   = SC_IDLE;
  int unsigned   lex_pos    = 0;
  int unsigned   lex_start  = 0;
  logic [39:0]   lex_prefix = '0;

  string kw_words [4]   = '{"let", "true", "false", "null"};
  string near_words [7] = '{"fals", "lets", "nul", "falsey", "truest", "le", "null_"};
  string pair_ops [7]   = '{"==", "!=", "<=", ">=", "&&", "||", "|>"};
  string punct          = "=!<>&|/+-*%(){}[],.:;";
  logic [7:0] ws_chars [6] = '{8'h20, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d};
  int unsigned idle_by_phase [4]  = '{0, 72, 0, 28};
  int unsigned stall_by_phase [4] = '{0, 0, 72, 28};

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  function automatic int unsigned next_pos(int unsigned p);
    return (p >= POS_MAX) ? POS_MAX : p + 1;
  endfunction

  function automatic int unsigned run_len(int unsigned from, int unsigned to);
    return (to > from) ? to - from : 0;
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_word(logic [7:0] c);
    return is_alpha(c) || is_digit(c) || c == sbt_pkg::CH_UNDERSCORE;
  endfunction

  function automatic bit is_space(logic [7:0] c);
    return c == " " || (c >= 8'h09 && c <= 8'h0d);
  endfunction

  // Queue one token of the current byte, fields cut to the port width
  function automatic void add_token(sbt_pkg::tok_kind_e k, int unsigned s, int unsigned l);
    sbt_pkg::tok_rec_t t;
    t.kind   = k;
    t.start  = s[sbt_pkg::FIELD_W-1:0];
    t.length = l[sbt_pkg::FIELD_W-1:0];
    t.last   = 1'b0;
    if (step_toks.size() < sbt_pkg::MAX_RESULTS) step_toks.insert(step_toks.size(), t);
  endfunction

  function automatic sbt_pkg::tok_kind_e word_kind();
    if (lex_prefix == sbt_pkg::KW_LET) return sbt_pkg::TK_LET;
    if (lex_prefix == sbt_pkg::KW_TRUE) return sbt_pkg::TK_TRUE;
    if (lex_prefix == sbt_pkg::KW_FALSE) return sbt_pkg::TK_FALSE;
    if (lex_prefix == sbt_pkg::KW_NULL) return sbt_pkg::TK_NULL;
    return sbt_pkg::TK_IDENT;
  endfunction

  function automatic void open_lexeme(scan_e m, int unsigned pos);
    lex_mode  = m;
    lex_start = pos;
  endfunction

  // Scan a byte with nothing pending
  function automatic void scan_fresh(logic [7:0] c, int unsigned pos);
    sbt_pkg::tok_kind_e k;
    k = sbt_pkg::TK_UNKNOWN;
    lex_mode = SC_IDLE;
    if (is_space(c)) return;
    case (c)
      "=": begin open_lexeme(SC_EQ, pos); return; end
      "!": begin open_lexeme(SC_BANG, pos); return; end
      "<": begin open_lexeme(SC_LT, pos); return; end
      ">": begin open_lexeme(SC_GT, pos); return; end
      "&": begin open_lexeme(SC_AMP, pos); return; end
      "|": begin open_lexeme(SC_PIPE, pos); return; end
      "/": begin open_lexeme(SC_SLASH, pos); return; end
      "\"": begin open_lexeme(SC_STRING, pos); return; end
      "+": k = sbt_pkg::TK_PLUS;
      "-": k = sbt_pkg::TK_MINUS;
      "*": k = sbt_pkg::TK_STAR;
      "%": k = sbt_pkg::TK_PERCENT;
      "(": k = sbt_pkg::TK_LPAREN;
      ")": k = sbt_pkg::TK_RPAREN;
      "{": k = sbt_pkg::TK_LBRACE;
      "}": k = sbt_pkg::TK_RBRACE;
      "[": k = sbt_pkg::TK_LBRACKET;
      "]": k = sbt_pkg::TK_RBRACKET;
      ",": k = sbt_pkg::TK_COMMA;
      ".": k = sbt_pkg::TK_DOT;
      ":": k = sbt_pkg::TK_COLON;
      ";": k = sbt_pkg::TK_SEMI;
      default: begin
        if (is_alpha(c) || c == sbt_pkg::CH_UNDERSCORE) begin
          open_lexeme(SC_IDENT, pos);
          lex_prefix = {32'h0, c};
          return;
        end
        if (is_digit(c)) begin
          open_lexeme(SC_INT, pos);
          return;
        end
      end
    endcase
    add_token(k, pos, 1);
  endfunction

  // Offer the byte to the pending lexeme; return 1 when it is consumed
  function automatic bit scan_cont(logic [7:0] c, int unsigned pos);
    int unsigned        s;
    int unsigned        incl;
    int unsigned        excl;
    sbt_pkg::tok_kind_e base;
    s    = lex_start;
    incl = run_len(s, next_pos(pos));
    excl = run_len(s, pos);
    case (lex_mode)
      SC_EQ, SC_BANG, SC_LT, SC_GT: begin
        base = (lex_mode == SC_EQ) ? sbt_pkg::TK_ASSIGN :
               (lex_mode == SC_BANG) ? sbt_pkg::TK_BANG :
               (lex_mode == SC_LT) ? sbt_pkg::TK_LT : sbt_pkg::TK_GT;
        if (c == "=") begin
          add_token(sbt_pkg::tok_kind_e'(base + 1), s, incl);
          lex_mode = SC_IDLE;
          return 1'b1;
        end
        add_token(base, s, excl);
        return 1'b0;
      end
      SC_AMP: begin
        if (c == "&") begin
          add_token(sbt_pkg::TK_ANDAND, s, incl);
          lex_mode = SC_IDLE;
          return 1'b1;
        end
        add_token(sbt_pkg::TK_UNKNOWN, s, excl);
        return 1'b0;
      end
      SC_PIPE: begin
        if (c == "|" || c == ">") begin
          add_token((c == "|") ? sbt_pkg::TK_OROR : sbt_pkg::TK_PIPEGT, s, incl);
          lex_mode = SC_IDLE;
          return 1'b1;
        end
        add_token(sbt_pkg::TK_UNKNOWN, s, excl);
        return 1'b0;
      end
      SC_SLASH: begin
        if (c == "/") begin
          lex_mode = SC_COMMENT;
          return 1'b1;
        end
        add_token(sbt_pkg::TK_SLASH, s, excl);
        return 1'b0;
      end
      SC_COMMENT: begin
        if (c == sbt_pkg::CH_NEWLINE) lex_mode = SC_IDLE;
        return 1'b1;
      end
      SC_STRING: begin
        if (c == "\"") begin
          add_token(sbt_pkg::TK_STRING, s, incl);
          lex_mode = SC_IDLE;
        end
        return 1'b1;
      end
      SC_IDENT: begin
        if (is_word(c)) begin
          // Saturate to all ones once the name outgrows five bytes
          if (lex_prefix[39:32] != 8'h00) lex_prefix = '1;
          else lex_prefix = {lex_prefix[31:0], c};
          return 1'b1;
        end
        add_token(word_kind(), s, excl);
        return 1'b0;
      end
      SC_INT: begin
        if (is_digit(c)) return 1'b1;
        if (c == ".") begin
          lex_mode = SC_INTDOT;
          return 1'b1;
        end
        add_token(sbt_pkg::TK_NUMBER, s, excl);
        return 1'b0;
      end
      SC_INTDOT: begin
        if (is_digit(c)) begin
          lex_mode = SC_FRAC;
          return 1'b1;
        end
        // Split off the trailing dot
        add_token(sbt_pkg::TK_NUMBER, s, run_len(s, run_len(1, pos)));
        add_token(sbt_pkg::TK_DOT, run_len(1, pos), 1);
        return 1'b0;
      end
      SC_FRAC: begin
        if (is_digit(c)) return 1'b1;
        add_token(sbt_pkg::TK_NUMBER, s, excl);
        return 1'b0;
      end
      default: return 1'b0;
    endcase
    return 1'b0;
  endfunction

  // Emit the pending lexeme when the source ends at stop_at
  function automatic void flush_lexeme(int unsigned stop_at);
    int unsigned s;
    int unsigned len;
    s   = lex_start;
    len = run_len(s, stop_at);
    case (lex_mode)
      SC_EQ: add_token(sbt_pkg::TK_ASSIGN, s, len);
      SC_BANG: add_token(sbt_pkg::TK_BANG, s, len);
      SC_LT: add_token(sbt_pkg::TK_LT, s, len);
      SC_GT: add_token(sbt_pkg::TK_GT, s, len);
      SC_AMP, SC_PIPE: add_token(sbt_pkg::TK_UNKNOWN, s, len);
      SC_SLASH: add_token(sbt_pkg::TK_SLASH, s, len);
      SC_STRING: add_token(sbt_pkg::TK_STRING, s, len);
      SC_IDENT: add_token(word_kind(), s, len);
      SC_INT, SC_FRAC: add_token(sbt_pkg::TK_NUMBER, s, len);
      SC_INTDOT: begin
        add_token(sbt_pkg::TK_NUMBER, s, run_len(s, run_len(1, stop_at)));
        add_token(sbt_pkg::TK_DOT, run_len(1, stop_at), 1);
      end
      default: ;
    endcase
    lex_mode = SC_IDLE;
  endfunction

  // Work out the tokens one accepted byte causes and queue them
  function automatic void predict_tokens(logic [7:0] c, logic fin);
    int unsigned       pos;
    int unsigned       stop_at;
    sbt_pkg::tok_rec_t t;
    pos = lex_pos;
    step_toks.delete();
    if (lex_mode == SC_IDLE || !scan_cont(c, pos)) scan_fresh(c, pos);
    if (fin) begin
      stop_at = next_pos(pos);
      flush_lexeme(stop_at);
      add_token(sbt_pkg::TK_END, stop_at, 0);
      lex_mode   = SC_IDLE;
      lex_pos    = 0;
      lex_start  = 0;
      lex_prefix = '0;
    end else begin
      lex_pos = next_pos(pos);
    end
    for (int i = 0; i < step_toks.size(); i++) begin
      t      = step_toks[i];
      t.last = (i == step_toks.size() - 1);
      token_expect_q.insert(token_expect_q.size(), t);
    end
  endfunction

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("%s", msg);
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  // Append one byte to the source under construction
  function automatic void put_char(logic [7:0] b);
    src_text.insert(src_text.size(), b);
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) put_char(s[i]);
  endfunction

  function automatic logic [7:0] word_char(bit leading);
    int unsigned r;
    r = $urandom_range(0, leading ? 52 : 62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r == 52) return sbt_pkg::CH_UNDERSCORE;
    return 8'("0" + r - 53);
  endfunction

  function automatic void put_digits();
    repeat ($urandom_range(1, 4)) put_char(8'("0" + $urandom_range(0, 9)));
  endfunction

  // Random bytes of any value but the one that would close the lexeme
  function automatic void put_filler(logic [7:0] stop_char);
    logic [7:0] b;
    repeat ($urandom_range(0, 5)) begin
      b = 8'($urandom_range(0, 255));
      if (b == stop_char) b = b ^ 8'h01;
      put_char(b);
    end
  endfunction

  // Append one lexeme, mostly well-formed, sometimes noise or broken
  function automatic void put_random_lexeme();
    case ($urandom_range(0, 19))
      0, 1: put_text(kw_words[$urandom_range(0, 3)]);
      2: put_text(near_words[$urandom_range(0, 6)]);
      3, 4: begin
        put_char(word_char(1'b1));
        repeat ($urandom_range(0, 7)) put_char(word_char(1'b0));
      end
      5, 6: put_digits();
      7: begin
        put_digits();
        put_char(".");
        put_digits();
      end
      8: begin
        put_digits();
        put_char(".");
      end
      9: begin
        put_char("\"");
        put_filler("\"");
        put_char("\"");
      end
      10: begin
        // Unterminated: swallows the rest of the source
        put_char("\"");
        put_filler("\"");
      end
      11: begin
        put_text("//");
        put_filler(sbt_pkg::CH_NEWLINE);
        put_char(sbt_pkg::CH_NEWLINE);
      end
      12, 13: put_text(pair_ops[$urandom_range(0, 6)]);
      14, 15: put_char(punct[$urandom_range(0, punct.len() - 1)]);
      16: repeat ($urandom_range(1, 3)) put_char(ws_chars[$urandom_range(0, 5)]);
      17, 18: put_char(8'($urandom_range(0, 255)));
      default: put_char(8'($urandom_range(0, 31)));
    endcase
  endfunction

  // Hand a byte to the driver, holding while its queue is full
  task automatic send_byte(logic [7:0] b, logic fin);
    src_byte_t item;
    while (byte_queue.size() >= QUEUE_DEPTH) @(negedge clk_i);
    item.value     = b;
    item.last_byte = fin;
    byte_queue.insert(byte_queue.size(), item);
    bytes_sent++;
  endtask

  // Send the assembled text as one source, final flag on its last byte
  task automatic send_source();
    for (int i = 0; i < src_text.size(); i++) begin
      send_byte(src_text[i], i == src_text.size() - 1);
    end
    src_text.delete();
  endtask

  // ---------------------------------------------------------------------
  // Clock and reset
  // ---------------------------------------------------------------------

  initial begin
    clk_i                = 1'b0;
    rst_ni               = 1'b0;
    byte_if.valid        = 1'b0;
    byte_if.source_byte  = 8'h00;
    byte_if.is_final     = 1'b0;
    token_if.ready       = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Byte driver: advance to the next queued byte once the transaction completes
  // ---------------------------------------------------------------------

  always @(posedge clk_i) begin : drive_bytes
    src_byte_t item;
    if (!rst_ni) begin
      byte_if.valid <= 1'b0;
    end else if (!byte_if.valid || byte_if.ready) begin
      if (byte_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        item = byte_queue.pop_front();
        byte_if.valid       <= 1'b1;
        byte_if.source_byte <= item.value;
        byte_if.is_final    <= item.last_byte;
      end else begin
        byte_if.valid <= 1'b0;
      end
    end
  end

  // Stall the token port at random
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      token_if.ready <= 1'b0;
    end else begin
      token_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: predict on each byte transaction, check each token transaction
  // ---------------------------------------------------------------------

  always @(posedge clk_i) begin : watch_ports
    sbt_pkg::tok_rec_t want;
    if (rst_ni) begin
      if (byte_if.valid && byte_if.ready) begin
        predict_tokens(byte_if.source_byte, byte_if.is_final);
      end
      if (token_if.valid && token_if.ready) begin
        if (token_expect_q.size() == 0) begin
          note_failure($sformatf("unexpected token: kind %0d start %0d length %0d last %0d",
                                 token_if.token_kind, token_if.token_start,
                                 token_if.token_length, token_if.run_last));
        end else begin
          want = token_expect_q.pop_front();
          if (token_if.token_kind !== want.kind || token_if.token_start !== want.start ||
              token_if.token_length !== want.length || token_if.run_last !== want.last) begin
            note_failure($sformatf(
              "token mismatch: expected kind %0d start %0d length %0d last %0d, got %0d %0d %0d %0d",
              want.kind, want.start, want.length, want.last, token_if.token_kind,
              token_if.token_start, token_if.token_length, token_if.run_last));
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------

  initial begin
    string       directed [7];
    int unsigned goal;
    directed = '{"&x|", "\"ab", "7.", "//c", "5.+", "!", "1.x"};

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed sources: lone & and |, open string, trailing dot, open comment,
    // four tokens from one byte, byte extremes
    foreach (directed[i]) begin
      put_text(directed[i]);
      send_source();
    end
    src_text = '{8'h00, 8'hff};
    send_source();
    src_text = '{8'h80, 8'h7f, 8'h01};
    send_source();

    // Random sources under each idling profile
    for (int ph = 0; ph < 4; ph++) begin
      while (byte_queue.size() != 0) @(negedge clk_i);
      send_idle_pct  = idle_by_phase[ph];
      recv_stall_pct = stall_by_phase[ph];
      goal = bytes_sent + PHASE_BYTES;
      while (bytes_sent < goal) begin
        repeat ($urandom_range(1, 8)) begin
          put_random_lexeme();
          if ($urandom_range(0, 1) != 0) put_char(" ");
        end
        send_source();
      end
    end

    // Drain: all bytes taken, all tokens seen, then a short quiet spell
    while (byte_queue.size() != 0 || byte_if.valid) @(posedge clk_i);
    while (token_expect_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (token_expect_q.size() != 0) begin
      note_failure($sformatf("%0d expected tokens never arrived", token_expect_q.size()));
    end
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* source_byte_tokenizer.f */
src/sbt_pkg.sv
src/sbt_if.sv
src/sbt_scan.sv
src/sbt_obuf.sv
src/source_byte_tokenizer.sv
tb/tb_source_byte_tokenizer.sv
